// ===== rtl/cbm_pkg.sv =====
// Shared constants, codes and controller/datapath types of the command buffer.
`default_nettype none
package cbm_pkg;
	localparam int DEPTH_DEF     = 5;
	localparam int ADDR_BITS_DEF = 8;

	localparam logic [3:0] ERASE_LIMIT_RST = 4'd10;
	localparam logic [3:0] SPAN_MAX        = 4'd15;

	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_ERASE = 2'd2;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_READ   = 2'd1;
	localparam logic [1:0] KIND_FLUSH  = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_READ_INIT,
		OP_READ_STEP,
		OP_COMPACT_INIT,
		OP_COMPACT_STEP,
		OP_COMPACT_END,
		OP_MERGE_STEP,
		OP_TAIL,
		OP_FLUSH_INIT,
		OP_EMIT_FLUSH,
		OP_EMIT_ACK,
		OP_EMIT_READ
	} cbm_op_t;

	typedef struct packed {
		logic is_read;
		logic is_write;
		logic is_erase;
		logic cnt_zero;
		logic full;
		logic scan_zero;
		logic compact_done;
		logic pending;
		logic flush_last;
		logic out_free;
	} cbm_status_t;
endpackage
`default_nettype wire

// ===== rtl/cbm_chan_if.sv =====
// Request and response channel interfaces of the command buffer.
`default_nettype none
interface cbm_req_if #(parameter int ADDR_BITS = cbm_pkg::ADDR_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic [1:0]           req_type;
	logic [ADDR_BITS-1:0] lba;
	logic [31:0]          write_value;
	logic [3:0]           erase_count;
	modport source (output valid, req_type, lba, write_value, erase_count, input ready);
	modport sink (input valid, req_type, lba, write_value, erase_count, output ready);
endinterface

interface cbm_rsp_if #(parameter int ADDR_BITS = cbm_pkg::ADDR_BITS_DEF);
	logic                 valid;
	logic                 ready;
	logic [1:0]           out_kind;
	logic                 read_hit;
	logic [31:0]          read_data;
	logic                 flush_is_erase;
	logic [ADDR_BITS-1:0] flush_lba;
	logic [31:0]          flush_value;
	logic [3:0]           flush_count;
	logic                 last;
	modport source (output valid, out_kind, read_hit, read_data, flush_is_erase, flush_lba,
		flush_value, flush_count, last, input ready);
	modport sink (input valid, out_kind, read_hit, read_data, flush_is_erase, flush_lba,
		flush_value, flush_count, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/cbm_ctrl.sv =====
// Sequencing state machine of the command buffer.
`default_nettype none
module cbm_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire cbm_pkg::cbm_status_t st,
	output cbm_pkg::cbm_op_t        op
);
	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_READ, S_REPLY, S_COMPACT, S_MERGE, S_TAIL, S_ACK, S_FLUSH
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		op      = cbm_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = cbm_pkg::OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (st.is_read) begin
					op      = cbm_pkg::OP_READ_INIT;
					state_d = S_READ;
				end else if (!(st.is_write || st.is_erase) || (st.is_erase && st.cnt_zero)) begin
					state_d = S_ACK;
				end else if (st.full) begin
					op      = cbm_pkg::OP_FLUSH_INIT;
					state_d = S_FLUSH;
				end else begin
					op      = cbm_pkg::OP_COMPACT_INIT;
					state_d = S_COMPACT;
				end
			end
			S_READ: begin
				if (st.scan_zero) begin
					state_d = S_REPLY;
				end else begin
					op = cbm_pkg::OP_READ_STEP;
				end
			end
			S_REPLY: begin
				if (st.out_free) begin
					op      = cbm_pkg::OP_EMIT_READ;
					state_d = S_IDLE;
				end
			end
			S_COMPACT: begin
				if (st.compact_done) begin
					op      = cbm_pkg::OP_COMPACT_END;
					state_d = st.is_write ? S_ACK : S_MERGE;
				end else begin
					op = cbm_pkg::OP_COMPACT_STEP;
				end
			end
			S_MERGE: begin
				if (st.scan_zero || !st.pending) begin
					state_d = S_TAIL;
				end else begin
					op = cbm_pkg::OP_MERGE_STEP;
				end
			end
			S_TAIL: begin
				op      = cbm_pkg::OP_TAIL;
				state_d = S_ACK;
			end
			S_ACK: begin
				if (st.out_free) begin
					op      = cbm_pkg::OP_EMIT_ACK;
					state_d = S_IDLE;
				end
			end
			S_FLUSH: begin
				if (st.out_free) begin
					op = cbm_pkg::OP_EMIT_FLUSH;
					if (st.flush_last) begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/cbm_dp.sv =====
// Entry storage, scan counters, merge arithmetic and output register of the command buffer.
`default_nettype none
module cbm_dp #(
	parameter int DEPTH     = cbm_pkg::DEPTH_DEF,
	parameter int ADDR_BITS = cbm_pkg::ADDR_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [3:0]           cfg_wdata,
	input  wire logic [1:0]           in_req_type,
	input  wire logic [ADDR_BITS-1:0] in_lba,
	input  wire logic [31:0]          in_write_value,
	input  wire logic [3:0]           in_erase_count,
	input  wire cbm_pkg::cbm_op_t     op,
	output cbm_pkg::cbm_status_t      st,
	input  wire logic                 out_ready,
	output logic                      out_valid,
	output logic [1:0]                out_kind,
	output logic                      out_read_hit,
	output logic [31:0]               out_read_data,
	output logic                      out_flush_is_erase,
	output logic [ADDR_BITS-1:0]      out_flush_lba,
	output logic [31:0]               out_flush_value,
	output logic [3:0]                out_flush_count,
	output logic                      out_last
);
	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = ADDR_BITS + 1;

	logic                 ent_er_q   [DEPTH];
	logic [ADDR_BITS-1:0] ent_addr_q [DEPTH];
	logic [31:0]          ent_data_q [DEPTH];
	logic [3:0]           ent_span_q [DEPTH];

	logic [CW-1:0]        count_q, sc_q, wp_q;
	logic [3:0]           limit_q;
	logic [1:0]           type_q;
	logic [ADDR_BITS-1:0] lba_q;
	logic [31:0]          val_q;
	logic [3:0]           cnt_q;
	logic [EW-1:0]        ns_q, ne_q;
	logic                 pending_q, hit_q;
	logic [31:0]          rdata_q;

	// One entry is looked at per cycle, except while a flush beat waits for the sink; the scan counter picks it.
	logic [CW-1:0]        sc_m1;
	logic [IW-1:0]        rd_idx;
	logic                 e_er;
	logic [ADDR_BITS-1:0] e_addr;
	logic [31:0]          e_data;
	logic [3:0]           e_span;
	logic [EW-1:0]        e_s, e_t, req_s, req_e;
	logic [3:0]           lim;

	assign sc_m1  = sc_q - CW'(1);
	assign rd_idx = (op == cbm_pkg::OP_COMPACT_STEP || op == cbm_pkg::OP_EMIT_FLUSH)
		? sc_q[IW-1:0] : sc_m1[IW-1:0];
	assign e_er   = ent_er_q[rd_idx];
	assign e_addr = ent_addr_q[rd_idx];
	assign e_data = ent_data_q[rd_idx];
	assign e_span = ent_span_q[rd_idx];
	assign e_s    = EW'(e_addr);
	assign e_t    = e_s + EW'(e_span) - EW'(1);
	assign req_s  = EW'(lba_q);
	assign req_e  = EW'(lba_q) + EW'(cnt_q) - EW'(1);
	assign lim    = (limit_q == 4'd0) ? 4'd1 : limit_q;

	// Read lookup on the chosen entry.
	logic [EW-1:0] rd_len;
	logic          rd_hit;
	assign rd_len = e_er ? EW'(e_span) : EW'(1);
	assign rd_hit = (req_s >= e_s) && (req_s < e_s + rd_len);

	// Compaction keeps every entry the new command does not supersede.
	logic keep;
	always_comb begin
		if (e_er) begin
			keep = 1'b1;
		end else if (type_q == cbm_pkg::REQ_WRITE) begin
			keep = (e_addr != lba_q);
		end else begin
			keep = !((e_s >= req_s) && (e_s <= req_e));
		end
	end

	// Merge of the pending erase range into the chosen older erase entry.
	logic          m_hit;
	logic [EW-1:0] m_ts, m_te, m_len;
	always_comb begin
		m_hit = 1'b1;
		m_ts  = e_s;
		m_te  = e_t;
		priority if (e_s <= ns_q && e_t <= ne_q && ns_q <= e_t) begin
			m_te = ne_q;
		end else if (e_s >= ns_q && e_t <= ne_q) begin
			m_ts = ns_q;
			m_te = ne_q;
		end else if (e_s <= ns_q && e_t >= ne_q) begin
			m_hit = 1'b1;
		end else if (e_s >= ns_q && e_t >= ne_q && e_s <= ne_q) begin
			m_ts = ns_q;
		end else begin
			m_hit = 1'b0;
		end
	end
	assign m_len = m_te - m_ts + EW'(1);

	logic [EW-1:0] tail_len;
	logic [3:0]    tail_span;
	assign tail_len  = ne_q - ns_q + EW'(1);
	assign tail_span = (tail_len > EW'(cbm_pkg::SPAN_MAX)) ? cbm_pkg::SPAN_MAX : tail_len[3:0];

	assign st.is_read      = (type_q == cbm_pkg::REQ_READ);
	assign st.is_write     = (type_q == cbm_pkg::REQ_WRITE);
	assign st.is_erase     = (type_q == cbm_pkg::REQ_ERASE);
	assign st.cnt_zero     = (cnt_q == 4'd0);
	assign st.full         = (count_q >= CW'(DEPTH));
	assign st.scan_zero    = (sc_q == '0);
	assign st.compact_done = (sc_q == count_q);
	assign st.pending      = pending_q;
	assign st.flush_last   = (sc_q == count_q - CW'(1));
	assign st.out_free     = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q   <= cbm_pkg::ERASE_LIMIT_RST;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (op == cbm_pkg::OP_EMIT_ACK || op == cbm_pkg::OP_EMIT_READ
				|| op == cbm_pkg::OP_EMIT_FLUSH) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (op)
				cbm_pkg::OP_COMPACT_END: begin
					count_q <= (type_q == cbm_pkg::REQ_WRITE) ? wp_q + CW'(1) : wp_q;
				end
				cbm_pkg::OP_TAIL: begin
					if (pending_q && !ns_q[ADDR_BITS]) begin
						count_q <= count_q + CW'(1);
					end
				end
				cbm_pkg::OP_EMIT_FLUSH: begin
					if (sc_q == count_q - CW'(1)) begin
						count_q <= CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			cbm_pkg::OP_LOAD: begin
				type_q <= in_req_type;
				lba_q  <= in_lba;
				val_q  <= in_write_value;
				cnt_q  <= in_erase_count;
			end
			cbm_pkg::OP_READ_INIT: begin
				sc_q    <= count_q;
				hit_q   <= 1'b0;
				rdata_q <= '0;
			end
			cbm_pkg::OP_READ_STEP: begin
				if (rd_hit) begin
					hit_q   <= 1'b1;
					rdata_q <= e_er ? 32'd0 : e_data;
					sc_q    <= '0;
				end else begin
					sc_q <= sc_m1;
				end
			end
			cbm_pkg::OP_COMPACT_INIT, cbm_pkg::OP_FLUSH_INIT: begin
				sc_q <= '0;
				wp_q <= '0;
			end
			cbm_pkg::OP_COMPACT_STEP: begin
				if (keep) begin
					ent_er_q[wp_q[IW-1:0]]   <= e_er;
					ent_addr_q[wp_q[IW-1:0]] <= e_addr;
					ent_data_q[wp_q[IW-1:0]] <= e_data;
					ent_span_q[wp_q[IW-1:0]] <= e_span;
					wp_q <= wp_q + CW'(1);
				end
				sc_q <= sc_q + CW'(1);
			end
			cbm_pkg::OP_COMPACT_END: begin
				if (type_q == cbm_pkg::REQ_WRITE) begin
					ent_er_q[wp_q[IW-1:0]]   <= 1'b0;
					ent_addr_q[wp_q[IW-1:0]] <= lba_q;
					ent_data_q[wp_q[IW-1:0]] <= val_q;
					ent_span_q[wp_q[IW-1:0]] <= 4'd0;
				end
				sc_q      <= wp_q;
				ns_q      <= req_s;
				ne_q      <= req_e;
				pending_q <= 1'b1;
			end
			cbm_pkg::OP_MERGE_STEP: begin
				if (e_er && m_hit) begin
					ent_addr_q[rd_idx] <= m_ts[ADDR_BITS-1:0];
					if (m_len > EW'(lim)) begin
						ent_span_q[rd_idx] <= lim;
						ns_q <= m_ts + EW'(lim);
						ne_q <= m_te;
					end else begin
						ent_span_q[rd_idx] <= m_len[3:0];
						pending_q <= 1'b0;
					end
				end
				sc_q <= sc_m1;
			end
			cbm_pkg::OP_TAIL: begin
				// A remainder that starts past the top address covers nothing.
				if (pending_q && !ns_q[ADDR_BITS]) begin
					ent_er_q[count_q[IW-1:0]]   <= 1'b1;
					ent_addr_q[count_q[IW-1:0]] <= ns_q[ADDR_BITS-1:0];
					ent_data_q[count_q[IW-1:0]] <= '0;
					ent_span_q[count_q[IW-1:0]] <= tail_span;
				end
			end
			cbm_pkg::OP_EMIT_FLUSH: begin
				out_kind           <= cbm_pkg::KIND_FLUSH;
				out_read_hit       <= 1'b0;
				out_read_data      <= '0;
				out_flush_is_erase <= e_er;
				out_flush_lba      <= e_addr;
				out_flush_value    <= e_er ? 32'd0 : e_data;
				out_flush_count    <= e_er ? e_span : 4'd0;
				out_last           <= (sc_q == count_q - CW'(1));
				sc_q               <= sc_q + CW'(1);
				// The new command replaces the buffer once the last entry leaves.
				if (sc_q == count_q - CW'(1)) begin
					ent_er_q[0]   <= (type_q == cbm_pkg::REQ_ERASE);
					ent_addr_q[0] <= lba_q;
					ent_data_q[0] <= (type_q == cbm_pkg::REQ_ERASE) ? 32'd0 : val_q;
					ent_span_q[0] <= (type_q == cbm_pkg::REQ_ERASE) ? cnt_q : 4'd0;
				end
			end
			cbm_pkg::OP_EMIT_ACK, cbm_pkg::OP_EMIT_READ: begin
				out_kind           <= (op == cbm_pkg::OP_EMIT_READ)
					? cbm_pkg::KIND_READ : cbm_pkg::KIND_ACCEPT;
				out_read_hit       <= (op == cbm_pkg::OP_EMIT_READ) && hit_q;
				out_read_data      <= (op == cbm_pkg::OP_EMIT_READ) ? rdata_q : 32'd0;
				out_flush_is_erase <= 1'b0;
				out_flush_lba      <= '0;
				out_flush_value    <= '0;
				out_flush_count    <= '0;
				out_last           <= 1'b1;
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

// ===== rtl/ssd_command_buffer_merge_top.sv =====
// Top level of the write-combining SSD command buffer.
`default_nettype none
// Holds up to DEPTH pending write and erase commands in arrival order and answers
// reads from them. One command is handled at a time, and one entry is visited per cycle
// through the single entry port, except while a flush beat waits for the sink. A read
// is a newest-first scan, a write is a compaction pass, an erase is a compaction pass
// and a merge pass, and a write or nonzero erase that meets a full buffer flushes
// every entry. Each result beat waits while the sink holds ready low. The next command
// is accepted at the earliest in the cycle after the last beat is issued.
// erase_limit is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, which the block itself does not enforce.
module ssd_command_buffer_merge_top #(
	parameter int DEPTH     = cbm_pkg::DEPTH_DEF,
	parameter int ADDR_BITS = cbm_pkg::ADDR_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata,
	cbm_req_if.sink         req,
	cbm_rsp_if.source       rsp
);
	cbm_pkg::cbm_op_t     op;
	cbm_pkg::cbm_status_t st;

	cbm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.st       (st),
		.op       (op)
	);

	cbm_dp #(.DEPTH(DEPTH), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_we             (cfg_we),
		.cfg_wdata          (cfg_wdata),
		.in_req_type        (req.req_type),
		.in_lba             (req.lba),
		.in_write_value     (req.write_value),
		.in_erase_count     (req.erase_count),
		.op                 (op),
		.st                 (st),
		.out_ready          (rsp.ready),
		.out_valid          (rsp.valid),
		.out_kind           (rsp.out_kind),
		.out_read_hit       (rsp.read_hit),
		.out_read_data      (rsp.read_data),
		.out_flush_is_erase (rsp.flush_is_erase),
		.out_flush_lba      (rsp.flush_lba),
		.out_flush_value    (rsp.flush_value),
		.out_flush_count    (rsp.flush_count),
		.out_last           (rsp.last)
	);
endmodule
`default_nettype wire

// ===== rtl/cbm_checker.sv =====
// Port-level assertions of the command buffer and their binding to the top level.
`default_nettype none
module cbm_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] out_kind,
	input wire logic       read_hit,
	input wire logic [31:0] read_data,
	input wire logic       last
);
	// A beat held back by the sink stays valid, with its kind and last flag unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(last))
		else $error("output beat changed while stalled");

	// One command at a time: right after an accepted beat the input is closed.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a command is in progress");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_kind == cbm_pkg::KIND_ACCEPT || out_kind == cbm_pkg::KIND_READ
			|| out_kind == cbm_pkg::KIND_FLUSH)
		else $error("unknown result kind");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind != cbm_pkg::KIND_FLUSH |-> last)
		else $error("single-beat result without last");

	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_kind == cbm_pkg::KIND_READ && !read_hit |-> read_data == 32'd0)
		else $error("read miss carries data");
endmodule

bind ssd_command_buffer_merge_top cbm_checker u_cbm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_kind  (rsp.out_kind),
	.read_hit  (rsp.read_hit),
	.read_data (rsp.read_data),
	.last      (rsp.last)
);
`default_nettype wire

// ===== test/ssd_command_buffer_merge_top_tb.sv =====
// Testbench for the write-combining SSD command buffer: directed and random commands checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module ssd_command_buffer_merge_top_tb;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic        hit;
		logic [31:0] rdata;
		logic        fe;
		logic [7:0]  flba;
		logic [31:0] fval;
		logic [3:0]  fcnt;
		logic        last;
	} reply_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [3:0] cfg_wdata;

	cbm_req_if #(.ADDR_BITS(8)) req ();
	cbm_rsp_if #(.ADDR_BITS(8)) rsp ();

	ssd_command_buffer_merge_top u_top (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.req(req), .rsp(rsp)
	);

	// Predictor copy of the buffer.
	logic        buf_erase [5];
	logic [7:0]  buf_addr [5];
	logic [31:0] buf_data [5];
	logic [3:0]  buf_span [5];
	int          buf_len;
	logic [3:0]  lim_reg;

	reply_t expected_replies[$];
	int errors = 0;
	int beats_in;
	int beats_out = 0;
	int flushes_seen = 0;
	int hold_requests;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic reply_t mk(logic [1:0] k, logic h, logic [31:0] d, logic fe,
		logic [7:0] fl, logic [31:0] fv, logic [3:0] fc, logic l);
		reply_t r;
		r.kind = k; r.hit = h; r.rdata = d; r.fe = fe;
		r.flba = fl; r.fval = fv; r.fcnt = fc; r.last = l;
		return r;
	endfunction

	task automatic queue_reply(reply_t r);
		expected_replies = {expected_replies, r};
	endtask

	task automatic drop_entry(int i);
		for (int j = i; j + 1 < buf_len; j++) begin
			buf_erase[j] = buf_erase[j+1];
			buf_addr[j] = buf_addr[j+1];
			buf_data[j] = buf_data[j+1];
			buf_span[j] = buf_span[j+1];
		end
		buf_len--;
	endtask

	task automatic add_entry(logic er, logic [7:0] a, logic [31:0] d, logic [3:0] s);
		if (buf_len < 5) begin
			buf_erase[buf_len] = er;
			buf_addr[buf_len] = a;
			buf_data[buf_len] = er ? 32'd0 : d;
			buf_span[buf_len] = er ? s : 4'd0;
			buf_len++;
		end
	endtask

	task automatic merge_erase(logic [7:0] a, logic [3:0] cnt);
		longint lim, ns, ne, ts, te;
		bit pend;
		int i;
		lim = (lim_reg == 4'd0) ? 1 : longint'(lim_reg);
		ns = longint'(a);
		ne = longint'(a) + longint'(cnt) - 1;
		pend = 1;
		i = 0;
		while (i < buf_len) begin
			if (!buf_erase[i] && buf_addr[i] >= ns && buf_addr[i] <= ne) drop_entry(i);
			else i++;
		end
		for (i = buf_len - 1; i >= 0; i--) begin
			if (!buf_erase[i]) continue;
			ts = longint'(buf_addr[i]);
			te = ts + longint'(buf_span[i]) - 1;
			if (ts <= ns && te <= ne && ns <= te) te = ne;
			else if (ts >= ns && te <= ne) begin
				ts = ns; te = ne;
			end else if (ts <= ns && te >= ne) begin
			end else if (ts >= ns && te >= ne && ts <= ne) ts = ns;
			else continue;
			buf_addr[i] = ts[7:0];
			if (te - ts + 1 > lim) begin
				buf_span[i] = lim[3:0];
				ns = ts + lim;
				ne = te;
			end else begin
				buf_span[i] = 4'(te - ts + 1);
				pend = 0;
				break;
			end
		end
		if (pend && ns <= 255) begin
			ts = ne - ns + 1;
			if (ts > 15) ts = 15;
			add_entry(1'b1, ns[7:0], 32'd0, ts[3:0]);
		end
	endtask

	task automatic predict_command(logic [1:0] t, logic [7:0] a, logic [31:0] v,
		logic [3:0] c);
		int i;
		if (t == cbm_pkg::REQ_READ) begin
			for (i = buf_len - 1; i >= 0; i--) begin
				if (a >= buf_addr[i] &&
					int'(a) < int'(buf_addr[i]) + (buf_erase[i] ? int'(buf_span[i]) : 1)) begin
					queue_reply(mk(cbm_pkg::KIND_READ, 1'b1,
						buf_erase[i] ? 32'd0 : buf_data[i], 1'b0, 8'd0, 32'd0, 4'd0, 1'b1));
					return;
				end
			end
			queue_reply(mk(cbm_pkg::KIND_READ, 1'b0, 32'd0, 1'b0, 8'd0, 32'd0, 4'd0, 1'b1));
			return;
		end
		if (t == REQ_UNUSED || (t == cbm_pkg::REQ_ERASE && c == 4'd0)) begin
			queue_reply(mk(cbm_pkg::KIND_ACCEPT, 1'b0, 32'd0, 1'b0, 8'd0, 32'd0, 4'd0, 1'b1));
			return;
		end
		if (buf_len >= 5) begin
			for (i = 0; i < buf_len; i++)
				queue_reply(mk(cbm_pkg::KIND_FLUSH, 1'b0, 32'd0, buf_erase[i], buf_addr[i],
					buf_erase[i] ? 32'd0 : buf_data[i], buf_erase[i] ? buf_span[i] : 4'd0,
					i + 1 == buf_len));
			buf_len = 0;
			if (t == cbm_pkg::REQ_WRITE) add_entry(1'b0, a, v, 4'd0);
			else add_entry(1'b1, a, 32'd0, c);
			return;
		end
		if (t == cbm_pkg::REQ_WRITE) begin
			i = 0;
			while (i < buf_len) begin
				if (!buf_erase[i] && buf_addr[i] == a) drop_entry(i);
				else i++;
			end
			add_entry(1'b0, a, v, 4'd0);
		end else merge_erase(a, c);
		queue_reply(mk(cbm_pkg::KIND_ACCEPT, 1'b0, 32'd0, 1'b0, 8'd0, 32'd0, 4'd0, 1'b1));
	endtask

	task automatic send_command(logic [1:0] t, logic [7:0] a, logic [31:0] v, logic [3:0] c);
		int gap;
		gap = $urandom_range(0, 7);
		repeat (gap) @(posedge clk);
		req.valid <= 1'b1;
		req.req_type <= t;
		req.lba <= a;
		req.write_value <= v;
		req.erase_count <= c;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		predict_command(t, a, v, c);
		beats_in++;
		req.valid <= 1'b0;
		// The next beat is driven at a later edge.
		@(posedge clk);
	endtask

	// Response side: random stalls, plus a long hold-off when requested.
	initial begin
		int stall;
		int holds_served;
		holds_served = 0;
		rsp.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_requests > holds_served) begin
				holds_served++;
				rsp.ready <= 1'b0;
				repeat (300) @(posedge clk);
				stall = 0;
			end else begin
				stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			end
			if (stall != 0) begin
				rsp.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = mk(rsp.out_kind, rsp.read_hit, rsp.read_data, rsp.flush_is_erase,
				rsp.flush_lba, rsp.flush_value, rsp.flush_count, rsp.last);
			beats_out++;
			if (got.kind == cbm_pkg::KIND_FLUSH) flushes_seen++;
			if (expected_replies.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual %h", $time, got);
				errors++;
			end else begin
				want = expected_replies.pop_front();
				if (got !== want) begin
					$display("%0t: mismatch, expected %h, actual %h", $time, want, got);
					errors++;
				end
			end
		end
	end

	task automatic drain;
		while (expected_replies.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic set_limit(logic [3:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		lim_reg = v;
	endtask

	task automatic test_directed;
		send_command(cbm_pkg::REQ_READ, 8'd0, 32'd0, 4'd0);
		send_command(cbm_pkg::REQ_WRITE, 8'd0, 32'hFFFF_FFFF, 4'd0);
		send_command(cbm_pkg::REQ_WRITE, 8'd255, 32'h0, 4'd0);
		send_command(cbm_pkg::REQ_WRITE, 8'd0, 32'hA5A5_5A5A, 4'd0);
		send_command(cbm_pkg::REQ_READ, 8'd0, 32'd0, 4'd0);
		send_command(cbm_pkg::REQ_ERASE, 8'd250, 32'd0, 4'd15);
		send_command(cbm_pkg::REQ_READ, 8'd255, 32'd0, 4'd0);
		send_command(cbm_pkg::REQ_ERASE, 8'd10, 32'd0, 4'd0);
		send_command(REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 4'hF);
		send_command(cbm_pkg::REQ_ERASE, 8'd20, 32'd0, 4'd8);
		send_command(cbm_pkg::REQ_ERASE, 8'd24, 32'd0, 4'd15);
		send_command(cbm_pkg::REQ_READ, 8'd30, 32'd0, 4'd0);
		send_command(cbm_pkg::REQ_WRITE, 8'd100, 32'h1234_5678, 4'd0);
		send_command(cbm_pkg::REQ_WRITE, 8'd101, 32'h8765_4321, 4'd0);
		send_command(cbm_pkg::REQ_ERASE, 8'd0, 32'd0, 4'd0);
		send_command(cbm_pkg::REQ_ERASE, 8'd60, 32'd0, 4'd15);
		send_command(cbm_pkg::REQ_READ, 8'd101, 32'd0, 4'd0);
		send_command(cbm_pkg::REQ_READ, 8'd200, 32'd0, 4'd0);
	endtask

	task automatic test_limits;
		set_limit(4'd0);
		send_command(cbm_pkg::REQ_ERASE, 8'd40, 32'd0, 4'd6);
		send_command(cbm_pkg::REQ_ERASE, 8'd42, 32'd0, 4'd9);
		set_limit(4'd15);
		send_command(cbm_pkg::REQ_ERASE, 8'd248, 32'd0, 4'd15);
		send_command(cbm_pkg::REQ_ERASE, 8'd240, 32'd0, 4'd15);
		send_command(cbm_pkg::REQ_READ, 8'd250, 32'd0, 4'd0);
		set_limit(4'd1);
		send_command(cbm_pkg::REQ_ERASE, 8'd254, 32'd0, 4'd4);
		send_command(cbm_pkg::REQ_ERASE, 8'd253, 32'd0, 4'd5);
	endtask

	task automatic test_random(int n);
		logic [1:0] t;
		logic [7:0] a;
		int r;
		for (int k = 0; k < n; k++) begin
			if (k % 120 == 119) set_limit(4'($urandom_range(0, 15)));
			r = $urandom_range(0, 99);
			if (r < 30) t = cbm_pkg::REQ_READ;
			else if (r < 60) t = cbm_pkg::REQ_WRITE;
			else if (r < 95) t = cbm_pkg::REQ_ERASE;
			else t = REQ_UNUSED;
			// Mostly a narrow window so entries overlap and merge.
			a = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'(8'd30 + $urandom_range(0, 24));
			if ($urandom_range(0, 9) == 0) a = 8'(8'd240 + $urandom_range(0, 15));
			send_command(t, a, $urandom, 4'($urandom_range(0, 15)));
		end
	endtask

	task automatic test_backpressure;
		drain();
		hold_requests++;
		for (int k = 0; k < 12; k++)
			send_command(cbm_pkg::REQ_WRITE, 8'(k * 3), $urandom, 4'd0);
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		req.valid = 0;
		req.req_type = 0;
		req.lba = 0;
		req.write_value = 0;
		req.erase_count = 0;
		buf_len = 0;
		lim_reg = cbm_pkg::ERASE_LIMIT_RST;
		beats_in = 0;
		hold_requests = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_limits();
		set_limit(4'd10);
		test_backpressure();
		test_random(500);
		drain();
		$display("Covered %0d commands and %0d result beats, %0d of them flushed entries.",
			beats_in, beats_out, flushes_seen);
		$display("Erase limits from zero to fifteen and a long receiver stall were exercised.");
		if (errors == 0 && expected_replies.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule
`default_nettype wire
